@@ design/cmpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cmpt_pkg
// shared constants, register indexes and helper types for the cloud mask
// pixel test pipeline
// ----------------------------------------------------------------------------
package cmpt_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int RATIO_FRAC_DEF   = 14;

    // quotient bits per divider and bits retired per divider stage
    localparam int QUO_W    = 16;
    localparam int DIV_STEP = 4;
    localparam int DIV_LAT  = QUO_W / DIV_STEP + 1;

    localparam int WHITE_FRAC = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANDS = 2'd1;

    localparam logic [15:0] SCALE_RST = 16'd1000;
    localparam logic [3:0]  BANDS_RST = 4'd9;

    localparam logic [3:0] MODE_ONE_THERMAL = 4'd7;
    localparam logic [3:0] MODE_TWO_THERMAL = 4'd8;

    // 0.7 in q4.12
    localparam logic [15:0] WHITE_LIMIT = 16'd2867;

    localparam int FLAG_BASIC = 0;
    localparam int FLAG_WHITE = 1;
    localparam int FLAG_HAZE  = 2;
    localparam int FLAG_NSWIR = 3;
    localparam int FLAG_WATER = 4;
    localparam int FLAG_PCP   = 5;
    localparam int FLAG_CLEAR = 6;
    localparam int FLAG_SNOW  = 7;

    typedef struct packed {
        logic nodata;
        logic satp;
        logic sat_green;
        logic sat_red;
        logic c_s2;
        logic c_t1;
        logic hot;
        logic nirswir;
        logic n_lt_11;
        logic n_lt_5;
        logic n_gt_11;
        logic cold;
        logic green_lit;
        logic bright;
        logic si_neg;
        logic si_zero;
        logic vi_neg;
        logic vi_zero;
        logic w_zero;
        logic sum_neg;
    } cmp_t;

    function automatic logic [15:0] ratio_fin(
        input logic [QUO_W-1:0] q,
        input logic             ovf,
        input logic             neg,
        input logic             zero
    );
        logic [QUO_W:0] qe;
        logic [15:0]    res;
        qe = {1'b0, q};
        if (zero)
        begin
            res = '0;
        end
        else if (ovf)
        begin
            res = neg ? 16'h8000 : 16'h7fff;
        end
        else if (neg)
        begin
            res = (qe >= 17'h08000) ? 16'h8000 : 16'(-qe);
        end
        else
        begin
            res = (q > 16'h7fff) ? 16'h7fff : 16'(q);
        end
        return res;
    endfunction

endpackage

@@ design/cmpt_div.sv @@
// ----------------------------------------------------------------------------
// cmpt_div
// pipelined unsigned restoring divider, num << SHIFT over den, with an
// overflow flag when the quotient does not fit in QUO_W bits
// ----------------------------------------------------------------------------
module cmpt_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 17,
    parameter int SHIFT = 14
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [NUM_W-1:0]            num,
    input  logic [DEN_W-1:0]            den,
    output logic [cmpt_pkg::QUO_W-1:0]  quo,
    output logic                        ovf
);
    import cmpt_pkg::*;

    localparam int NF    = NUM_W + SHIFT;
    localparam int CMP_W = (NF > DEN_W + QUO_W) ? NF : DEN_W + QUO_W;
    localparam int NST   = QUO_W / DIV_STEP;

    logic [NF-1:0]    full;
    logic [DEN_W-1:0] r0_next;
    logic             ovf_next;

    logic [DEN_W-1:0] r_reg   [0:NST];
    logic [DEN_W-1:0] den_reg [0:NST];
    logic [QUO_W-1:0] low_reg [0:NST];
    logic [QUO_W-1:0] q_reg   [0:NST];
    logic             ovf_reg [0:NST];

    logic [DEN_W-1:0] r_next   [0:NST-1];
    logic [QUO_W-1:0] low_next [0:NST-1];
    logic [QUO_W-1:0] q_next   [0:NST-1];

    assign full     = NF'(num) << SHIFT;
    assign r0_next  = DEN_W'(full >> QUO_W);
    assign ovf_next = CMP_W'(full) >= (CMP_W'(den) << QUO_W);

    always_comb
    begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] r;
        logic [QUO_W-1:0] lo;
        logic [QUO_W-1:0] q;
        for (int k = 0; k < NST; k++)
        begin
            r  = r_reg[k];
            lo = low_reg[k];
            q  = q_reg[k];
            for (int i = 0; i < DIV_STEP; i++)
            begin
                t  = {r, lo[QUO_W-1]};
                lo = lo << 1;
                q  = q << 1;
                if (t >= {1'b0, den_reg[k]})
                begin
                    t    = t - {1'b0, den_reg[k]};
                    q[0] = 1'b1;
                end
                r = t[DEN_W-1:0];
            end
            r_next[k]   = r;
            low_next[k] = lo;
            q_next[k]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= r0_next;
            den_reg[0] <= den;
            low_reg[0] <= full[QUO_W-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            for (int k = 0; k < NST; k++)
            begin
                r_reg[k+1]   <= r_next[k];
                den_reg[k+1] <= den_reg[k];
                low_reg[k+1] <= low_next[k];
                q_reg[k+1]   <= q_next[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quo = q_reg[NST];
    assign ovf = ovf_reg[NST];

endmodule

@@ design/cloud_mask_pixel_tests.sv @@
// ----------------------------------------------------------------------------
// cloud_mask_pixel_tests
// potential cloud pixel tests on one multispectral pixel per beat
// ----------------------------------------------------------------------------
// usage
//   pixel channel: pix_valid / pix_ready with one port per band plus the
//   saturation mask. result channel: res_valid / res_ready with indices,
//   mean, whiteness, variability probability and the eight test flags.
//   config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   scale_factor (0) or band_count (1); other indexes are dropped. write
//   config only while the pipeline is empty.
//   stages: a pixel beat, once taken, passes the input stage, five divider
//   stages and two finishing stages before its result leaves.
//   throughput: one pixel per cycle while the output is not stalled, set by
//   the three pipelined dividers retiring four quotient bits per stage.
//   stall: when res_valid is high and res_ready low the whole pipeline
//   holds and pix_ready drops; nothing is lost or repeated.
//   reset: pipeline empties, scale_factor returns to 1000, band_count to 9.
// ----------------------------------------------------------------------------
module cloud_mask_pixel_tests #(
    parameter int SAMPLE_WIDTH    = cmpt_pkg::SAMPLE_WIDTH_DEF,
    parameter int RATIO_FRAC_BITS = cmpt_pkg::RATIO_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cmpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cmpt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      coastal,
    input  logic signed [SAMPLE_WIDTH-1:0]      blue,
    input  logic signed [SAMPLE_WIDTH-1:0]      green,
    input  logic signed [SAMPLE_WIDTH-1:0]      red,
    input  logic signed [SAMPLE_WIDTH-1:0]      nir,
    input  logic signed [SAMPLE_WIDTH-1:0]      swir_one,
    input  logic signed [SAMPLE_WIDTH-1:0]      swir_two,
    input  logic signed [SAMPLE_WIDTH-1:0]      thermal_one,
    input  logic signed [SAMPLE_WIDTH-1:0]      thermal_two,
    input  logic [8:0]                          saturated_mask,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic                                valid_res,
    output logic signed [15:0]                  snow_index,
    output logic signed [15:0]                  vegetation_index,
    output logic signed [15:0]                  mean_visible,
    output logic [15:0]                         whiteness,
    output logic signed [17:0]                  variability_prob,
    output logic signed [15:0]                  mod_vegetation_index,
    output logic signed [15:0]                  mod_snow_index,
    output logic [7:0]                          test_flags
);
    import cmpt_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int F   = RATIO_FRAC_BITS;
    localparam int DW  = SW + 1;
    localparam int WNW = SW + 3;
    localparam int CW  = (SW + 10 > 26) ? SW + 10 : 26;
    localparam int MW  = (SW + 2 > 18) ? SW + 2 : 18;
    localparam int VW  = 21;
    localparam int UP  = (F >= WHITE_FRAC) ? 0 : WHITE_FRAC - F;
    localparam int DN  = (F >= WHITE_FRAC) ? F - WHITE_FRAC : 0;

    localparam int FC_080 = (4 * (1 << F)) / 5;
    localparam int FC_015 = (3 * (1 << F)) / 20;
    localparam int FC_010 = (1 << F) / 10;
    localparam int FC_001 = (1 << F) / 100;

    localparam int MEAN_K = SW + 4;
    localparam logic [SW+2:0] RECIP = (SW + 3)'((64'd1 << MEAN_K) / 64'd3 + 64'd1);

    // config registers
    logic [15:0] scale_factor_reg;
    logic [3:0]  band_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= SCALE_RST;
            band_count_reg   <= BANDS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCALE: scale_factor_reg <= cfg_data;
                REG_BANDS: band_count_reg   <= cfg_data[3:0];
                default:   ;
            endcase
        end
    end

    // pipeline advance
    logic res_valid_reg;
    logic adv;

    assign adv       = !res_valid_reg || res_ready;
    assign pix_ready = adv;

    // input stage
    logic mode_one;
    logic mode_coastal;
    logic signed [CW-1:0] xb, xg, xr, xn, xs1, xs2, xt1, xsf, xsum;
    logic signed [DW-1:0] si_num, si_den, vi_num, vi_den;
    logic [DW-1:0]        si_num_m, si_den_m, vi_num_m, vi_den_m;
    logic signed [SW+1:0] sum_s;
    logic signed [SW+3:0] dev_b, dev_g, dev_r;
    logic [SW+3:0]        abs_b, abs_g, abs_r;
    logic [WNW-1:0]       wnum;
    logic [SW:0]          sum_m;
    cmp_t                 cmp_next;

    assign mode_one     = band_count_reg == MODE_ONE_THERMAL;
    assign mode_coastal = !mode_one && band_count_reg != MODE_TWO_THERMAL;

    assign xb   = CW'(blue);
    assign xg   = CW'(green);
    assign xr   = CW'(red);
    assign xn   = CW'(nir);
    assign xs1  = CW'(swir_one);
    assign xs2  = CW'(swir_two);
    assign xt1  = CW'(thermal_one);
    assign xsf  = CW'(signed'({1'b0, scale_factor_reg}));
    assign xsum = xb + xg + xr;

    assign si_num   = DW'(green) - DW'(swir_one);
    assign si_den   = DW'(green) + DW'(swir_one);
    assign vi_num   = DW'(nir) - DW'(red);
    assign vi_den   = DW'(nir) + DW'(red);
    assign si_num_m = si_num[DW-1] ? DW'(-si_num) : DW'(si_num);
    assign si_den_m = si_den[DW-1] ? DW'(-si_den) : DW'(si_den);
    assign vi_num_m = vi_num[DW-1] ? DW'(-vi_num) : DW'(vi_num);
    assign vi_den_m = vi_den[DW-1] ? DW'(-vi_den) : DW'(vi_den);

    assign sum_s = (SW + 2)'(blue) + (SW + 2)'(green) + (SW + 2)'(red);
    assign dev_b = (SW + 4)'(blue) + (SW + 4)'(blue) + (SW + 4)'(blue) - (SW + 4)'(sum_s);
    assign dev_g = (SW + 4)'(green) + (SW + 4)'(green) + (SW + 4)'(green)
                 - (SW + 4)'(sum_s);
    assign dev_r = (SW + 4)'(red) + (SW + 4)'(red) + (SW + 4)'(red) - (SW + 4)'(sum_s);
    assign abs_b = dev_b[SW+3] ? (SW + 4)'(-dev_b) : (SW + 4)'(dev_b);
    assign abs_g = dev_g[SW+3] ? (SW + 4)'(-dev_g) : (SW + 4)'(dev_g);
    assign abs_r = dev_r[SW+3] ? (SW + 4)'(-dev_r) : (SW + 4)'(dev_r);
    assign wnum  = WNW'(abs_b) + WNW'(abs_g) + WNW'(abs_r);
    assign sum_m = (SW + 1)'(sum_s[SW+1] ? -sum_s : sum_s);

    always_comb
    begin
        cmp_next.nodata    = mode_one ? (thermal_one == '0)
                                      : (thermal_one == '0 && thermal_two == '0);
        cmp_next.satp      = (|saturated_mask[7:1]) || (mode_coastal && saturated_mask[0])
                          || (!mode_one && saturated_mask[8]);
        cmp_next.sat_green = saturated_mask[2];
        cmp_next.sat_red   = saturated_mask[3];
        cmp_next.c_s2      = (xs2 * 100) > (xsf * 3);
        cmp_next.c_t1      = xt1 < (xsf * 27);
        cmp_next.hot       = (xb * 100 - xr * 50) > (xsf * 8);
        if (xs1 > 0)
        begin
            cmp_next.nirswir = (xn * 4) > (xs1 * 3);
        end
        else if (xs1 < 0)
        begin
            cmp_next.nirswir = (xn * 4) < (xs1 * 3);
        end
        else
        begin
            cmp_next.nirswir = 1'b0;
        end
        cmp_next.n_lt_11   = (xn * 100) < (xsf * 11);
        cmp_next.n_lt_5    = (xn * 100) < (xsf * 5);
        cmp_next.n_gt_11   = (xn * 100) > (xsf * 11);
        cmp_next.cold      = (xt1 * 10) < (xsf * 38);
        cmp_next.green_lit = (xg * 10) > xsf;
        cmp_next.bright    = (xsum * 100) > (xsf * 135);
        cmp_next.si_neg    = si_num[DW-1] ^ si_den[DW-1];
        cmp_next.si_zero   = si_den == '0;
        cmp_next.vi_neg    = vi_num[DW-1] ^ vi_den[DW-1];
        cmp_next.vi_zero   = vi_den == '0;
        cmp_next.w_zero    = sum_s == '0;
        cmp_next.sum_neg   = sum_s[SW+1];
    end

    logic           a_valid_reg;
    cmp_t           a_cmp_reg;
    logic [DW-1:0]  a_si_num_reg, a_si_den_reg, a_vi_num_reg, a_vi_den_reg;
    logic [WNW-1:0] a_wnum_reg;
    logic [SW:0]    a_sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cmp_reg    <= cmp_next;
            a_si_num_reg <= si_num_m;
            a_si_den_reg <= si_den_m;
            a_vi_num_reg <= vi_num_m;
            a_vi_den_reg <= vi_den_m;
            a_wnum_reg   <= wnum;
            a_sum_reg    <= sum_m;
        end
    end

    // divider stages
    logic [QUO_W-1:0] si_q, vi_q, w_q;
    logic             si_ovf, vi_ovf, w_ovf;

    cmpt_div #(.NUM_W(DW), .DEN_W(DW), .SHIFT(F)) u_div_si (
        .clk (clk),
        .en  (adv),
        .num (a_si_num_reg),
        .den (a_si_den_reg),
        .quo (si_q),
        .ovf (si_ovf)
    );

    cmpt_div #(.NUM_W(DW), .DEN_W(DW), .SHIFT(F)) u_div_vi (
        .clk (clk),
        .en  (adv),
        .num (a_vi_num_reg),
        .den (a_vi_den_reg),
        .quo (vi_q),
        .ovf (vi_ovf)
    );

    cmpt_div #(.NUM_W(WNW), .DEN_W(SW + 1), .SHIFT(WHITE_FRAC)) u_div_w (
        .clk (clk),
        .en  (adv),
        .num (a_wnum_reg),
        .den (a_sum_reg),
        .quo (w_q),
        .ovf (w_ovf)
    );

    logic        side_valid_reg [0:DIV_LAT-1];
    cmp_t        side_cmp_reg   [0:DIV_LAT-1];
    logic [SW:0] side_sum_reg   [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_cmp_reg[0] <= a_cmp_reg;
            side_sum_reg[0] <= a_sum_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_cmp_reg[k] <= side_cmp_reg[k-1];
                side_sum_reg[k] <= side_sum_reg[k-1];
            end
        end
    end

    // finishing stage one: saturate ratios, tests
    cmp_t               sc;
    logic signed [15:0] si_next, vi_next, mod_si_next, mod_vi_next;
    logic [15:0]        white_pre, white_next;
    logic               basic, wtest_pre, wtest, water, pcp, clear_land, snow, override;
    logic [7:0]         flags_next;

    assign sc = side_cmp_reg[DIV_LAT-1];

    always_comb
    begin
        si_next    = signed'(ratio_fin(si_q, si_ovf, sc.si_neg, sc.si_zero));
        vi_next    = signed'(ratio_fin(vi_q, vi_ovf, sc.vi_neg, sc.vi_zero));
        white_pre  = sc.w_zero ? 16'h0000 : (w_ovf ? 16'hffff : 16'(w_q));
        basic      = sc.c_s2 && sc.c_t1 && (int'(vi_next) < FC_080)
                  && (int'(si_next) < FC_080);
        wtest_pre  = white_pre < WHITE_LIMIT;
        water      = ((int'(vi_next) < FC_001) && sc.n_lt_11)
                  || ((int'(vi_next) < FC_010) && sc.n_lt_5);
        override   = sc.satp && sc.bright;
        pcp        = override || (basic && wtest_pre && sc.hot && sc.nirswir);
        wtest      = override || wtest_pre;
        white_next = override ? 16'h0000 : white_pre;
        clear_land = !pcp && !water;
        snow       = (int'(si_next) > FC_015) && sc.cold && sc.n_gt_11 && sc.green_lit;
        mod_si_next = sc.sat_green ? 16'sd0 : si_next;
        mod_vi_next = sc.sat_red ? 16'sd0 : vi_next;
        flags_next = '0;
        flags_next[FLAG_BASIC] = basic;
        flags_next[FLAG_WHITE] = wtest;
        flags_next[FLAG_HAZE]  = sc.hot;
        flags_next[FLAG_NSWIR] = sc.nirswir;
        flags_next[FLAG_WATER] = water;
        flags_next[FLAG_PCP]   = pcp;
        flags_next[FLAG_CLEAR] = clear_land;
        flags_next[FLAG_SNOW]  = snow;
    end

    logic               c_valid_reg;
    logic               c_nodata_reg;
    logic               c_sum_neg_reg;
    logic [SW:0]        c_sum_reg;
    logic signed [15:0] c_si_reg, c_vi_reg, c_mod_si_reg, c_mod_vi_reg;
    logic [15:0]        c_white_reg;
    logic [7:0]         c_flags_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_nodata_reg  <= sc.nodata;
            c_sum_neg_reg <= sc.sum_neg;
            c_sum_reg     <= side_sum_reg[DIV_LAT-1];
            c_si_reg      <= si_next;
            c_vi_reg      <= vi_next;
            c_mod_si_reg  <= mod_si_next;
            c_mod_vi_reg  <= mod_vi_next;
            c_white_reg   <= white_next;
            c_flags_reg   <= flags_next;
        end
    end

    // finishing stage two: variability probability and mean
    logic signed [16:0]   msi_x, mvi_x;
    logic [16:0]          msi_abs, mvi_abs;
    logic [VW-1:0]        q12_si, q12_vi, vmax;
    logic signed [VW:0]   vp;
    logic signed [17:0]   vprob_next;
    logic [2*SW+3:0]      mean_prod;
    logic [SW:0]          mean_q;
    logic signed [MW-1:0] mean_m, mean_s;
    logic signed [15:0]   mean_next;

    always_comb
    begin
        msi_x   = 17'(c_mod_si_reg);
        mvi_x   = 17'(c_mod_vi_reg);
        msi_abs = msi_x[16] ? 17'(-msi_x) : 17'(msi_x);
        mvi_abs = mvi_x[16] ? 17'(-mvi_x) : 17'(mvi_x);
        q12_si  = (VW'(msi_abs) << UP) >> DN;
        q12_vi  = (VW'(mvi_abs) << UP) >> DN;
        vmax    = q12_vi;
        if (q12_si > vmax)
        begin
            vmax = q12_si;
        end
        if (VW'(c_white_reg) > vmax)
        begin
            vmax = VW'(c_white_reg);
        end
        vp = (VW + 1)'(4096) - signed'({1'b0, vmax});
        if (vp < -131072)
        begin
            vprob_next = -18'sd131072;
        end
        else if (vp > 131071)
        begin
            vprob_next = 18'sd131071;
        end
        else
        begin
            vprob_next = 18'(vp);
        end

        mean_prod = (2 * SW + 4)'(c_sum_reg) * (2 * SW + 4)'(RECIP);
        mean_q    = (SW + 1)'(mean_prod >> MEAN_K);
        mean_m    = MW'(mean_q);
        mean_s    = c_sum_neg_reg ? -mean_m : mean_m;
        if (mean_s < -32768)
        begin
            mean_next = -16'sd32768;
        end
        else if (mean_s > 32767)
        begin
            mean_next = 16'sd32767;
        end
        else
        begin
            mean_next = 16'(mean_s);
        end
    end

    logic               valid_res_reg;
    logic signed [15:0] snow_index_reg, vegetation_index_reg, mean_visible_reg;
    logic [15:0]        whiteness_reg;
    logic signed [17:0] variability_prob_reg;
    logic signed [15:0] mod_vegetation_index_reg, mod_snow_index_reg;
    logic [7:0]         test_flags_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (c_nodata_reg)
            begin
                valid_res_reg            <= 1'b0;
                snow_index_reg           <= '0;
                vegetation_index_reg     <= '0;
                mean_visible_reg         <= '0;
                whiteness_reg            <= '0;
                variability_prob_reg     <= '0;
                mod_vegetation_index_reg <= '0;
                mod_snow_index_reg       <= '0;
                test_flags_reg           <= '0;
            end
            else
            begin
                valid_res_reg            <= 1'b1;
                snow_index_reg           <= c_si_reg;
                vegetation_index_reg     <= c_vi_reg;
                mean_visible_reg         <= mean_next;
                whiteness_reg            <= c_white_reg;
                variability_prob_reg     <= vprob_next;
                mod_vegetation_index_reg <= c_mod_vi_reg;
                mod_snow_index_reg       <= c_mod_si_reg;
                test_flags_reg           <= c_flags_reg;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                side_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_valid_reg       <= pix_valid;
            side_valid_reg[0] <= a_valid_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_valid_reg[k] <= side_valid_reg[k-1];
            end
            c_valid_reg   <= side_valid_reg[DIV_LAT-1];
            res_valid_reg <= c_valid_reg;
        end
    end

    assign res_valid            = res_valid_reg;
    assign valid_res            = valid_res_reg;
    assign snow_index           = snow_index_reg;
    assign vegetation_index     = vegetation_index_reg;
    assign mean_visible         = mean_visible_reg;
    assign whiteness            = whiteness_reg;
    assign variability_prob     = variability_prob_reg;
    assign mod_vegetation_index = mod_vegetation_index_reg;
    assign mod_snow_index       = mod_snow_index_reg;
    assign test_flags           = test_flags_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> a_valid_reg)
        else $error("accepted pixel beat not captured");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !pix_ready)
        else $error("pipeline took a pixel while the output was stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !valid_res |-> test_flags == '0 && whiteness == '0
                                    && variability_prob == '0)
        else $error("no-data result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(test_flags[FLAG_CLEAR]
                        && (test_flags[FLAG_PCP] || test_flags[FLAG_WATER])))
        else $error("clear land flagged together with cloud or water");

endmodule

@@ tb/sv/cloud_mask_pixel_tests_tb.sv @@
// ----------------------------------------------------------------------------
// cloud_mask_pixel_tests_tb
// self-checking bench for the potential cloud pixel tests: pixels are driven
// through the valid/ready channel under random gaps and back-pressure, each
// result beat is compared field by field with an in-bench prediction, and
// the register settings are swept between phases
// ----------------------------------------------------------------------------
module cloud_mask_pixel_tests_tb;

    import cmpt_pkg::*;

    typedef struct packed {
        logic signed [15:0] coastal;
        logic signed [15:0] blue;
        logic signed [15:0] green;
        logic signed [15:0] red;
        logic signed [15:0] nir;
        logic signed [15:0] swir_one;
        logic signed [15:0] swir_two;
        logic signed [15:0] thermal_one;
        logic signed [15:0] thermal_two;
        logic [8:0]         sat;
    } pixel_t;

    typedef struct packed {
        logic               vld;
        logic signed [15:0] ndsi;
        logic signed [15:0] ndvi;
        logic signed [15:0] mean;
        logic [15:0]        white;
        logic signed [17:0] vprob;
        logic signed [15:0] mndvi;
        logic signed [15:0] mndsi;
        logic [7:0]         flags;
    } pixel_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    pixel_t pix = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    pixel_res_t got;

    pixel_t pixel_q[$];
    pixel_res_t expected_q[$];
    longint scale_cur = 1000;
    int bands_cur = 9;
    int mismatches = 0;
    int gap_cnt = 0;
    int stall_cnt = 0;
    int hold_off = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;

    cloud_mask_pixel_tests uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pix_valid(pix_valid), .pix_ready(pix_ready),
        .coastal(pix.coastal), .blue(pix.blue), .green(pix.green), .red(pix.red),
        .nir(pix.nir), .swir_one(pix.swir_one), .swir_two(pix.swir_two),
        .thermal_one(pix.thermal_one), .thermal_two(pix.thermal_two),
        .saturated_mask(pix.sat),
        .res_valid(res_valid), .res_ready(res_ready),
        .valid_res(got.vld), .snow_index(got.ndsi), .vegetation_index(got.ndvi),
        .mean_visible(got.mean), .whiteness(got.white),
        .variability_prob(got.vprob), .mod_vegetation_index(got.mndvi),
        .mod_snow_index(got.mndsi), .test_flags(got.flags)
    );

    always #4 clk = ~clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint diff_ratio(longint a, longint b);
        if (a + b == 0)
            return 0;
        return clamp(((a - b) * 16384) / (a + b), -32768, 32767);
    endfunction

    function automatic pixel_res_t pixel_tests(pixel_t p);
        pixel_res_t o;
        longint s, b, g, r, n, s1, s2, t1, sum, wnum, white, ndsi, ndvi;
        longint mndsi, mndvi, vmax;
        logic basic, wtest, hot, nsw, water, pcp, snow, satp;
        s = scale_cur;
        b = p.blue; g = p.green; r = p.red; n = p.nir;
        s1 = p.swir_one; s2 = p.swir_two; t1 = p.thermal_one;
        o = '0;
        if (bands_cur == 7 ? (t1 == 0) : (t1 == 0 && p.thermal_two == 0))
            return o;
        ndsi = diff_ratio(g, s1);
        ndvi = diff_ratio(n, r);
        basic = (100 * s2 > 3 * s) && (t1 < 27 * s) && (ndvi < 13107) && (ndsi < 13107);
        sum = b + g + r;
        wnum = mag(3 * b - sum) + mag(3 * g - sum) + mag(3 * r - sum);
        white = (sum == 0) ? 0 : clamp((wnum * 4096) / mag(sum), 0, 65535);
        wtest = white < 2867;
        hot = 100 * b - 50 * r > 8 * s;
        nsw = s1 > 0 ? (4 * n > 3 * s1) : (s1 < 0 ? (4 * n < 3 * s1) : 1'b0);
        water = ((ndvi < 163) && (100 * n < 11 * s)) || ((ndvi < 1638) && (100 * n < 5 * s));
        pcp = basic && wtest && hot && nsw;
        satp = (p.sat[7:1] != 0) || (bands_cur != 7 && bands_cur != 8 && p.sat[0])
            || (bands_cur != 7 && p.sat[8]);
        if (satp && (100 * sum > 135 * s))
        begin
            pcp = 1'b1;
            wtest = 1'b1;
            white = 0;
        end
        mndsi = p.sat[2] ? 0 : ndsi;
        mndvi = p.sat[3] ? 0 : ndvi;
        vmax = mag(mndvi) >>> 2;
        if ((mag(mndsi) >>> 2) > vmax)
            vmax = mag(mndsi) >>> 2;
        if (white > vmax)
            vmax = white;
        snow = (ndsi > 2457) && (10 * t1 < 38 * s) && (100 * n > 11 * s) && (10 * g > s);
        o.vld = 1'b1;
        o.ndsi = 16'(ndsi);
        o.ndvi = 16'(ndvi);
        o.mean = 16'(clamp(sum / 3, -32768, 32767));
        o.white = 16'(white);
        o.vprob = 18'(clamp(4096 - vmax, -131072, 131071));
        o.mndvi = 16'(mndvi);
        o.mndsi = 16'(mndsi);
        o.flags = {snow, !pcp && !water, pcp, water, nsw, hot, wtest, basic};
        return o;
    endfunction

    function automatic logic signed [15:0] rand_band(int s);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sd0;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, s > 20000 ? 20000 : s + s / 2));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        int s;
        s = int'(scale_cur);
        p.coastal = rand_band(s);
        p.blue = rand_band(s);
        p.green = rand_band(s);
        p.red = rand_band(s);
        p.nir = rand_band(s);
        p.swir_one = rand_band(s);
        p.swir_two = rand_band(s);
        p.thermal_one = ($urandom_range(0, 3) == 0) ? 16'($urandom)
            : 16'($urandom_range(0, 30 * s > 32767 ? 32767 : 30 * s));
        p.thermal_two = 16'($urandom);
        if ($urandom_range(0, 15) == 0)
            p.thermal_one = 0;
        if ($urandom_range(0, 15) == 0)
            p.thermal_two = 0;
        p.sat = ($urandom_range(0, 2) == 0) ? 9'($urandom) : 9'd0;
        return p;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (pix_valid && pix_ready)
            expected_q.push_back(pixel_tests(pix));
        if (!pix_valid || pix_ready)
        begin
            if (gap_cnt > 0)
            begin
                gap_cnt <= gap_cnt - 1;
                pix_valid <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                pix <= pixel_q.pop_front();
                pix_valid <= 1'b1;
                gap_cnt <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
            end
            else
                pix_valid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_off <= 60;
            hold_done <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result beat %p", got);
            end
            else if (got !== expected_q[0])
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("mismatch: expected %p actual %p", expected_q[0], got);
                void'(expected_q.pop_front());
            end
            else
                void'(expected_q.pop_front());
        end
        if (hold_off > 0)
        begin
            res_ready <= 1'b0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt <= stall_cnt - 1;
            res_ready <= 1'b0;
        end
        else if (!res_ready || (res_valid && res_ready))
        begin
            if (!res_ready || $urandom_range(0, 2) != 0)
                res_ready <= 1'b1;
            else
            begin
                stall_cnt <= $urandom_range(0, 13);
                res_ready <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SCALE)
            scale_cur = val;
        else if (idx == REG_BANDS)
            bands_cur = (val[3:0] == 7 || val[3:0] == 8) ? int'(val[3:0]) : 9;
    endtask

    task automatic drain();
        wait (pixel_q.size() == 0 && !pix_valid && expected_q.size() == 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic send_phase(int count);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(rand_pixel());
        drain();
    endtask

    initial
    begin
        pixel_t p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: reset settings
        p = '0;
        p.thermal_one = 16'sd1000;
        pixel_q.push_back(p);
        p.thermal_one = 0;
        p.thermal_two = 16'sd5;
        pixel_q.push_back(p);
        p.thermal_two = 0;
        pixel_q.push_back(p);
        p = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 9'h1ff};
        pixel_q.push_back(p);
        p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000, 9'h000};
        pixel_q.push_back(p);
        // likely potential cloud
        p = '{16'sd0, 16'sd400, 16'sd380, 16'sd360, 16'sd500, 16'sd400,
              16'sd300, 16'sd10000, 16'sd10000, 9'h000};
        pixel_q.push_back(p);
        p.sat = 9'h001;
        p.blue = 16'sd600; p.green = 16'sd600; p.red = 16'sd600;
        pixel_q.push_back(p);
        p.sat = 9'h100;
        pixel_q.push_back(p);
        p.sat = 9'h00c;
        pixel_q.push_back(p);
        // snow-like, water-like, opposing sums
        p = '{16'sd0, 16'sd800, 16'sd800, 16'sd700, 16'sd300, 16'sd100,
              16'sd50, 16'sd1000, 16'sd0, 9'h000};
        pixel_q.push_back(p);
        p = '{16'sd0, 16'sd50, 16'sd40, 16'sd30, 16'sd20, 16'sd0,
              16'sd10, 16'sd20000, 16'sd0, 9'h000};
        pixel_q.push_back(p);
        p = '{16'sd0, 16'sd100, -16'sd100, 16'sd0, -16'sd300, 16'sd100,
              16'sd10, 16'sd200, 16'sd0, 9'h000};
        pixel_q.push_back(p);
        p.swir_one = -16'sd400; p.nir = -16'sd400; p.red = 16'sd400;
        pixel_q.push_back(p);
        drain();
        write_reg(REG_BANDS, 16'd7);
        p = '0;
        p.thermal_two = 16'sd3;
        pixel_q.push_back(p);
        p.thermal_one = 16'sd3; p.sat = 9'h101;
        p.blue = 16'sd2000; p.green = 16'sd2000;
        pixel_q.push_back(p);
        drain();
        write_reg(2'd2, 16'd3);
        write_reg(2'd3, 16'd8);
        // long back-pressure while the sender keeps offering
        hold_go = 1'b1;
        send_phase(150);
        write_reg(REG_SCALE, 16'd0);
        write_reg(REG_BANDS, 16'd8);
        send_phase(150);
        write_reg(REG_SCALE, 16'd1);
        write_reg(REG_BANDS, 16'd15);
        send_phase(150);
        write_reg(REG_SCALE, 16'd65535);
        send_phase(150);
        write_reg(REG_BANDS, 16'd9);
        write_reg(REG_SCALE, 16'd10000);
        send_phase(300);
        for (int k = 0; k < 5; k++)
        begin
            write_reg(REG_SCALE, 16'($urandom_range(1, 65535)));
            write_reg(REG_BANDS, 16'($urandom_range(0, 15)));
            send_phase(200);
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
